FILE: hw/rtl/bhs_pkg.sv
// Shared types and constants for the bounded history stack.
// Used by the channel interfaces, the register block, the core and the top level.
package bhs_pkg;

	localparam int DEPTH_DEFAULT        = 16;
	localparam int FILE_ID_BITS_DEFAULT = 16;
	localparam int CMD_W                = 3;
	localparam int TOPIC_W              = 32;
	localparam int POS_W                = 16;
	localparam int MAX_ENTRIES_W        = 5;
	localparam int APB_DATA_W           = 32;
	localparam int APB_ADDR_W           = 3;

	localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RESET = 5'd16;

	// Register indexes, in word units of the configuration address space.
	typedef enum logic [0:0] {
		REG_MAX_ENTRIES = 1'b0,
		REG_NONE        = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH      = 3'd0,
		CMD_POP       = 3'd1,
		CMD_SET_POS   = 3'd2,
		CMD_CLEAR_POS = 3'd3,
		CMD_EMPTY     = 3'd4
	} cmd_t;

endpackage

FILE: hw/rtl/bhs_if.sv
// Channel interfaces for command words and result words.
// Depend on bhs_pkg for field widths.
interface bhs_in_if #(
	parameter int FILE_ID_BITS = bhs_pkg::FILE_ID_BITS_DEFAULT
);
	import bhs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [FILE_ID_BITS-1:0] file_id;
	logic [TOPIC_W-1:0]      topic_offset;
	logic [POS_W-1:0]        vert_pos;

	modport source (output valid, cmd, file_id, topic_offset, vert_pos, input ready);
	modport sink   (input valid, cmd, file_id, topic_offset, vert_pos, output ready);
endinterface

interface bhs_out_if #(
	parameter int FILE_ID_BITS = bhs_pkg::FILE_ID_BITS_DEFAULT,
	parameter int CNT_W        = 5
);
	import bhs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    ok;
	logic [FILE_ID_BITS-1:0] out_file_id;
	logic [TOPIC_W-1:0]      out_topic_offset;
	logic [POS_W-1:0]        out_vert_pos;
	logic [CNT_W-1:0]        entries_held;
	logic                    back_enabled;

	modport source (output valid, ok, out_file_id, out_topic_offset, out_vert_pos,
		entries_held, back_enabled, input ready);
	modport sink   (input valid, ok, out_file_id, out_topic_offset, out_vert_pos,
		entries_held, back_enabled, output ready);
endinterface

FILE: hw/rtl/bhs_cfg.sv
// APB-style register block holding the entry limit.
// Depends on bhs_pkg for the register map and reset value.
module bhs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bhs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [bhs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bhs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [bhs_pkg::MAX_ENTRIES_W-1:0] max_entries
);
	import bhs_pkg::*;

	logic [MAX_ENTRIES_W-1:0] max_entries_q;
	reg_idx_t                 reg_idx;
	logic                     wr_en;

	// Registers sit on word addresses; the low two address bits are ignored.
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RESET;
		end else if (wr_en && (reg_idx == REG_MAX_ENTRIES)) begin
			max_entries_q <= pwdata[MAX_ENTRIES_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_ENTRIES: prdata = {{(APB_DATA_W-MAX_ENTRIES_W){1'b0}}, max_entries_q};
			default:         prdata = '0;
		endcase
	end

	assign max_entries = max_entries_q;
endmodule

FILE: hw/rtl/bhs_core.sv
// History ring, top pointer, entry count and result register.
// Depends on bhs_pkg and the channel interfaces in bhs_if.sv.
module bhs_core #(
	parameter int DEPTH        = bhs_pkg::DEPTH_DEFAULT,
	parameter int FILE_ID_BITS = bhs_pkg::FILE_ID_BITS_DEFAULT,
	parameter int CNT_W        = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bhs_pkg::MAX_ENTRIES_W-1:0] max_entries,
	bhs_in_if.sink                            in_ch,
	bhs_out_if.source                         out_ch
);
	import bhs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > MAX_ENTRIES_W) ? CNT_W : MAX_ENTRIES_W;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
	localparam logic [CMP_W-1:0] LIM_DEPTH = CMP_W'(DEPTH);

	// Input register.
	logic                    valid_s1;
	logic [CMD_W-1:0]        cmd_s1;
	logic [FILE_ID_BITS-1:0] file_id_s1;
	logic [TOPIC_W-1:0]      topic_s1;
	logic [POS_W-1:0]        pos_s1;

	// History state; entries have no reset and are read only once written.
	logic [FILE_ID_BITS-1:0] file_ids_q [DEPTH];
	logic [TOPIC_W-1:0]      offsets_q  [DEPTH];
	logic [POS_W-1:0]        positions_q[DEPTH];
	logic [IDX_W-1:0]        top_q;
	logic [CNT_W-1:0]        count_q;

	// Result register.
	logic                    out_valid_q;
	logic                    ok_q;
	logic [FILE_ID_BITS-1:0] ofid_q;
	logic [TOPIC_W-1:0]      ooff_q;
	logic [POS_W-1:0]        opos_q;
	logic [CNT_W-1:0]        held_q;
	logic                    back_q;

	logic             advance;
	logic             fire;
	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] max_ext;
	logic [CMP_W-1:0] count_ext;
	logic [IDX_W-1:0] top_inc;
	logic [IDX_W-1:0] top_dec;
	logic [IDX_W-1:0] top_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic             ok_nxt;
	logic             pop_ok;
	logic             do_push;
	logic             do_set;
	logic             do_clear;

	assign advance     = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	// Effective limit: zero acts as one, anything above the ring size as the ring size.
	assign max_ext   = CMP_W'(max_entries);
	assign count_ext = CMP_W'(count_q);
	always_comb begin
		if (max_ext == '0) begin
			lim = CMP_W'(1);
		end else if (max_ext > LIM_DEPTH) begin
			lim = LIM_DEPTH;
		end else begin
			lim = max_ext;
		end
	end

	assign top_inc = (top_q == IDX_LAST) ? '0 : top_q + IDX_W'(1);
	assign top_dec = (top_q == '0) ? IDX_LAST : top_q - IDX_W'(1);

	always_comb begin
		top_nxt   = top_q;
		count_nxt = count_q;
		ok_nxt    = 1'b0;
		pop_ok    = 1'b0;
		do_push   = 1'b0;
		do_set    = 1'b0;
		do_clear  = 1'b0;
		case (cmd_t'(cmd_s1))
			CMD_PUSH: begin
				top_nxt = (count_q == '0) ? '0 : top_inc;
				if (count_ext < lim) begin
					count_nxt = count_q + CNT_W'(1);
				end
				do_push = 1'b1;
				ok_nxt  = 1'b1;
			end
			CMD_POP: begin
				if (count_q > CNT_W'(1)) begin
					top_nxt   = top_dec;
					count_nxt = count_q - CNT_W'(1);
					pop_ok    = 1'b1;
					ok_nxt    = 1'b1;
				end
			end
			CMD_SET_POS: begin
				do_set = (count_q != '0);
				ok_nxt = (count_q != '0);
			end
			CMD_CLEAR_POS: begin
				do_clear = (count_q != '0);
				ok_nxt   = (count_q != '0);
			end
			CMD_EMPTY: begin
				top_nxt   = '0;
				count_nxt = '0;
				ok_nxt    = 1'b1;
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			top_q       <= '0;
			count_q     <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				top_q   <= top_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1     <= in_ch.cmd;
			file_id_s1 <= in_ch.file_id;
			topic_s1   <= in_ch.topic_offset;
			pos_s1     <= in_ch.vert_pos;
		end
		if (fire) begin
			ok_q   <= ok_nxt;
			held_q <= count_nxt;
			back_q <= (count_nxt > CNT_W'(1));
			// The popped-to entry is not written in this cycle, so the read sees its value.
			ofid_q <= pop_ok ? file_ids_q[top_dec] : '0;
			ooff_q <= pop_ok ? offsets_q[top_dec] : '0;
			opos_q <= pop_ok ? positions_q[top_dec] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			file_ids_q[top_nxt] <= file_id_s1;
			offsets_q[top_nxt]  <= topic_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (fire && do_clear) begin
				positions_q[i] <= '0;
			end else if (fire && do_push && (top_nxt == IDX_W'(i))) begin
				positions_q[i] <= '0;
			end else if (fire && do_set && (top_q == IDX_W'(i))) begin
				positions_q[i] <= pos_s1;
			end
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.ok               = ok_q;
	assign out_ch.out_file_id      = ofid_q;
	assign out_ch.out_topic_offset = ooff_q;
	assign out_ch.out_vert_pos     = opos_q;
	assign out_ch.entries_held     = held_q;
	assign out_ch.back_enabled     = back_q;
endmodule

FILE: hw/rtl/bounded_history_stack_top.sv
// Bounded back-navigation history stack. Each command word (push, pop, set top position,
// clear all positions, empty) gives exactly one result word. A command is taken into an
// input register, resolved combinationally against the entry ring and held in a result
// register, so one word per cycle is sustained while the result side takes words. The
// entry limit is set through the APB register at address 0 (reset 16, zero acts as one).
// Entries read by a pop are always ones written by an earlier push.
module bounded_history_stack_top #(
	parameter int DEPTH        = bhs_pkg::DEPTH_DEFAULT,
	parameter int FILE_ID_BITS = bhs_pkg::FILE_ID_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bhs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bhs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bhs_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	bhs_in_if.sink                         in_ch,
	bhs_out_if.source                      out_ch
);
	import bhs_pkg::*;

	logic [MAX_ENTRIES_W-1:0] max_entries;

	bhs_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_entries (max_entries)
	);

	bhs_core #(
		.DEPTH        (DEPTH),
		.FILE_ID_BITS (FILE_ID_BITS),
		.CNT_W        ($clog2(DEPTH + 1))
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_entries (max_entries),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);
endmodule

FILE: bench/tb_bounded_history_stack_top.sv
// Self-checking testbench for bounded_history_stack_top: drives command words, predicts every
// result word and compares them field by field. Depends on bhs_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tb_bounded_history_stack_top;
	import bhs_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int FID_W       = FILE_ID_BITS_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RESULT_LAT  = 2;

	// Command codes that the block ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FID_W-1:0]   file_id;
		logic [TOPIC_W-1:0] topic_offset;
		logic [POS_W-1:0]   vert_pos;
	} history_cmd_t;

	typedef struct packed {
		logic                     ok;
		logic [FID_W-1:0]         file_id;
		logic [TOPIC_W-1:0]       topic_offset;
		logic [POS_W-1:0]         vert_pos;
		logic [MAX_ENTRIES_W-1:0] held;
		logic                     back;
	} history_outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bhs_in_if  in_ch ();
	bhs_out_if out_ch ();

	bounded_history_stack_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// Predicted copy of the entry ring and the limit register.
	logic [FID_W-1:0]         hist_file_id [DEPTH];
	logic [TOPIC_W-1:0]       hist_offset [DEPTH];
	logic [POS_W-1:0]         hist_pos [DEPTH];
	int unsigned              hist_top;
	int unsigned              hist_count;
	logic [MAX_ENTRIES_W-1:0] hist_limit;

	history_outcome_t awaited_outcomes[$];

	int    error_count      = 0;
	int    words_sent       = 0;
	int    words_checked    = 0;
	int    limits_written   = 0;
	int    cycle_count      = 0;
	bit    sender_idles     = 1'b0;
	bit    receiver_idles   = 1'b0;
	int    receiver_hold    = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_history_stack_top verification failed");
			$finish;
		end
	end

	function automatic history_outcome_t step_history(input history_cmd_t w);
		history_outcome_t r;
		int unsigned      lim;
		r = '0;
		lim = (hist_limit == 0) ? 1 : ((hist_limit > DEPTH) ? DEPTH : 32'(hist_limit));
		case (w.cmd)
			CMD_PUSH: begin
				hist_top = (hist_count == 0) ? 0 : (hist_top + 1) % DEPTH;
				hist_file_id[hist_top] = w.file_id;
				hist_offset[hist_top] = w.topic_offset;
				hist_pos[hist_top] = '0;
				if (hist_count < lim)
					hist_count++;
				r.ok = 1'b1;
			end
			CMD_POP: begin
				if (hist_count > 1) begin
					hist_top = (hist_top + DEPTH - 1) % DEPTH;
					hist_count--;
					r.file_id = hist_file_id[hist_top];
					r.topic_offset = hist_offset[hist_top];
					r.vert_pos = hist_pos[hist_top];
					r.ok = 1'b1;
				end
			end
			CMD_SET_POS: begin
				if (hist_count != 0) begin
					hist_pos[hist_top] = w.vert_pos;
					r.ok = 1'b1;
				end
			end
			CMD_CLEAR_POS: begin
				if (hist_count != 0) begin
					foreach (hist_pos[i])
						hist_pos[i] = '0;
					r.ok = 1'b1;
				end
			end
			CMD_EMPTY: begin
				hist_count = 0;
				hist_top = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.held = hist_count[MAX_ENTRIES_W-1:0];
		r.back = (hist_count > 1);
		return r;
	endfunction

	function automatic history_cmd_t make_word(input logic [CMD_W-1:0] cmd,
		input logic [FID_W-1:0] fid, input logic [TOPIC_W-1:0] topic,
		input logic [POS_W-1:0] pos);
		history_cmd_t w;
		w.cmd = cmd;
		w.file_id = fid;
		w.topic_offset = topic;
		w.vert_pos = pos;
		return w;
	endfunction

	// Mostly pushes and pops with random payload, some position and empty commands, and a little noise from unused codes.
	function automatic history_cmd_t random_word(input int unsigned push_weight);
		int unsigned      roll;
		logic [CMD_W-1:0] cmd;
		roll = $urandom_range(0, 99);
		if (roll < push_weight)
			cmd = CMD_PUSH;
		else if (roll < push_weight + (85 - push_weight) * 2 / 3)
			cmd = CMD_POP;
		else if (roll < 91)
			cmd = CMD_SET_POS;
		else if (roll < 95)
			cmd = CMD_CLEAR_POS;
		else if (roll < 97)
			cmd = CMD_EMPTY;
		else
			cmd = CMD_W'(32'(CMD_UNUSED_FIRST)
				+ $urandom_range(0, 32'(CMD_UNUSED_LAST - CMD_UNUSED_FIRST)));
		return make_word(cmd, FID_W'($urandom_range(0, 16'hFFFF)), $urandom(),
			POS_W'($urandom_range(0, 16'hFFFF)));
	endfunction

	// Called right after a falling edge; returns right after the falling edge that follows
	// acceptance, so the caller's next assignment to valid lands in that same step.
	task automatic send_word(input history_cmd_t w);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= w.cmd;
		in_ch.file_id <= w.file_id;
		in_ch.topic_offset <= w.topic_offset;
		in_ch.vert_pos <= w.vert_pos;
		do @(posedge clk); while (!in_ch.ready);
		awaited_outcomes.push_back(step_history(w));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results(input int settle);
		in_ch.valid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] expv,
		input logic [63:0] gotv);
		if (gotv !== expv) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, gotv);
			error_count++;
		end
	endtask

	task automatic write_limit(input logic [MAX_ENTRIES_W-1:0] value);
		drain_results(RESULT_LAT + 2);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_MAX_ENTRIES, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		hist_limit = value;
		limits_written++;
		@(negedge clk);
		// The address still selects the limit register, so the read data shows the new value.
		check_field("max_entries", 64'(value), 64'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		history_outcome_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_outcomes.size() == 0) begin
				$error("result word arrived with no command outstanding");
				error_count++;
			end else begin
				e = awaited_outcomes.pop_front();
				check_field("ok", 64'(e.ok), 64'(out_ch.ok));
				check_field("out_file_id", 64'(e.file_id), 64'(out_ch.out_file_id));
				check_field("out_topic_offset", 64'(e.topic_offset),
					64'(out_ch.out_topic_offset));
				check_field("out_vert_pos", 64'(e.vert_pos), 64'(out_ch.out_vert_pos));
				check_field("entries_held", 64'(e.held), 64'(out_ch.entries_held));
				check_field("back_enabled", 64'(e.back), 64'(out_ch.back_enabled));
				words_checked++;
			end
		end
	end

	// Result side: a random wait before each word when receiver_idles is set, plus a long hold when one is requested.
	initial begin
		int unsigned gap;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (receiver_hold) @(negedge clk);
				receiver_hold = 0;
			end else begin
				gap = receiver_idles ? $urandom_range(0, 8) : 0;
				if (gap != 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic test_directed_corners();
		send_word(make_word(CMD_POP, '0, '0, '0));
		send_word(make_word(CMD_SET_POS, '0, '0, 16'hFFFF));
		send_word(make_word(CMD_CLEAR_POS, '0, '0, '0));
		send_word(make_word(CMD_EMPTY, '0, '0, '0));
		send_word(make_word(CMD_UNUSED_FIRST, '1, '1, '1));
		send_word(make_word(CMD_PUSH, '0, '0, '0));
		send_word(make_word(CMD_PUSH, '1, '1, '1));
		send_word(make_word(CMD_SET_POS, '0, '0, 16'hFFFF));
		send_word(make_word(CMD_PUSH, 16'h5A5A, 32'h8000_0001, 16'h1234));
		// The pop must return the all-ones entry with the position written above.
		send_word(make_word(CMD_POP, '0, '0, '0));
		send_word(make_word(CMD_CLEAR_POS, '0, '0, '0));
		send_word(make_word(CMD_POP, '0, '0, '0));
		send_word(make_word(CMD_POP, '1, '1, '1));
		send_word(make_word(CMD_SET_POS, '0, '0, '0));
		send_word(make_word(CMD_UNUSED_MID, '0, '0, '0));
		send_word(make_word(CMD_UNUSED_LAST, '0, '0, '0));
		send_word(make_word(CMD_EMPTY, '1, '1, '1));
		send_word(make_word(CMD_POP, '0, '0, '0));
	endtask

	task automatic test_limit_overwrite();
		write_limit(5'd1);
		repeat (3) send_word(random_word(100));
		send_word(make_word(CMD_POP, '0, '0, '0));
		send_word(make_word(CMD_SET_POS, '0, '0, 16'hA5A5));
		write_limit(5'd0);
		repeat (3) send_word(random_word(100));
		send_word(make_word(CMD_POP, '0, '0, '0));
		write_limit(5'd31);
		repeat (20) send_word(random_word(100));
		repeat (17) send_word(make_word(CMD_POP, '0, '0, '0));
		write_limit(5'd16);
		repeat (10) send_word(random_word(100));
		// Lowering the limit below the count leaves the count where it is.
		write_limit(5'd3);
		repeat (4) send_word(random_word(100));
		repeat (12) send_word(make_word(CMD_POP, '0, '0, '0));
	endtask

	task automatic test_random_phases();
		logic [MAX_ENTRIES_W-1:0] limits [8];
		limits = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd17, 5'd9};
		for (int p = 0; p < 8; p++) begin
			write_limit(limits[p]);
			sender_idles = (p % 4 == 0) || (p % 4 == 1);
			receiver_idles = (p % 4 == 0) || (p % 4 == 2);
			repeat (150) send_word(random_word((p % 2 == 0) ? 60 : 40));
		end
	endtask

	task automatic test_backpressure();
		write_limit(5'd16);
		sender_idles = 1'b0;
		receiver_idles = 1'b1;
		receiver_hold = 300;
		repeat (60) send_word(random_word(55));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.file_id = '0;
		in_ch.topic_offset = '0;
		in_ch.vert_pos = '0;
		foreach (hist_file_id[i]) begin
			hist_file_id[i] = '0;
			hist_offset[i] = '0;
			hist_pos[i] = '0;
		end
		hist_top = 0;
		hist_count = 0;
		hist_limit = MAX_ENTRIES_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_corners();
		test_limit_overwrite();
		test_random_phases();
		test_backpressure();

		drain_results(RESULT_LAT + 8);
		$display("Checked %0d of %0d command words across %0d limit writes.",
			words_checked, words_sent, limits_written);
		$display("Stimulus: all commands and unused codes, overwrite at limit, long result stall.");
		if (error_count == 0)
			$display("bounded_history_stack_top verification clean");
		else
			$display("bounded_history_stack_top verification failed");
		$finish;
	end

endmodule
